// ----- hw/rtl/cnf_pkg.sv -----
// ----------------------------------------------------------------------------
// cnf_pkg
// Shared types and constants of the normalized 3x3 convolution filter.
// ----------------------------------------------------------------------------
package cnf_pkg;

	localparam int PIX_W      = 8;
	localparam int COEF_W     = 16;
	localparam int KSIZE      = 3;
	localparam int KTAPS      = KSIZE * KSIZE;
	localparam int TAP_IDX_W  = $clog2(KTAPS);
	localparam int POS_W      = 11;
	localparam int FILT_W     = 17;
	localparam int ACC_W      = 28;
	localparam int MAG_W      = ACC_W - 1;
	localparam int NORM_W     = 19;
	localparam int OUT_FRAC   = 8;
	localparam int DIV_W      = MAG_W + OUT_FRAC;
	localparam int DIV_CNT_W  = $clog2(DIV_W);
	localparam int HGT_W      = 12;
	localparam int MAX_HEIGHT = 2048;
	localparam int CFG_W      = 48;
	localparam int CFG_IDX_W  = 3;
	localparam int GEOM_W     = 12;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_TOP   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MID   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BOT   = 3'd4;

	localparam logic [CFG_W-1:0] KERNEL_TOP_RST = 48'd0;
	localparam logic [CFG_W-1:0] KERNEL_MID_RST = 48'd256;
	localparam logic [CFG_W-1:0] KERNEL_BOT_RST = 48'd0;
	localparam logic [GEOM_W-1:0] WIDTH_RST     = 12'd640;
	localparam logic [GEOM_W-1:0] HEIGHT_RST    = 12'd480;

	typedef struct packed {
		logic capture;
		logic shift;
		logic mac_step;
		logic div_start;
		logic div_step;
		logic load_out;
	} cnf_cmd_t;

	typedef struct packed {
		logic produce;
		logic mac_last;
		logic div_last;
		logic zero_kernel;
		logic out_busy;
	} cnf_sts_t;

endpackage

// ----- hw/rtl/cnf_if.sv -----
// ----------------------------------------------------------------------------
// cnf_if
// Valid/ready channels for pixel input and filter results.
// ----------------------------------------------------------------------------
interface cnf_pixel_if;
	import cnf_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel;
	modport source (output valid, output pixel, input ready);
	modport sink (input valid, input pixel, output ready);
endinterface

interface cnf_result_if;
	import cnf_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [FILT_W-1:0] filtered;
	logic [POS_W-1:0]         out_row;
	logic [POS_W-1:0]         out_col;
	logic                     frame_last;
	logic                     zero_kernel;
	modport source (output valid, output filtered, output out_row, output out_col,
		output frame_last, output zero_kernel, input ready);
	modport sink (input valid, input filtered, input out_row, input out_col,
		input frame_last, input zero_kernel, output ready);
endinterface

// ----- hw/rtl/cnf_ctrl.sv -----
// ----------------------------------------------------------------------------
// cnf_ctrl
// Sequencer: capture, window shift, 9-tap MAC, divide, result load.
// ----------------------------------------------------------------------------
module cnf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output cnf_pkg::cnf_cmd_t cmd,
	input  cnf_pkg::cnf_sts_t sts
);
	import cnf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MAC,
		ST_DIVINIT,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd           = '0;
		in_ready      = (state_q == ST_IDLE);
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.shift     = (state_q == ST_SHIFT);
		cmd.mac_step  = (state_q == ST_MAC);
		cmd.div_start = (state_q == ST_DIVINIT);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.load_out  = (state_q == ST_OUT) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					state_q <= sts.produce ? ST_MAC : ST_IDLE;
				end
				ST_MAC: begin
					if (sts.mac_last) state_q <= ST_DIVINIT;
				end
				ST_DIVINIT: begin
					state_q <= sts.zero_kernel ? ST_OUT : ST_DIV;
				end
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!sts.out_busy) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_capture_shift: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> cmd.shift)
		else $error("capture not followed by window shift");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.capture, cmd.shift, cmd.mac_step, cmd.div_start,
			cmd.div_step, cmd.load_out}))
		else $error("overlapping datapath commands");

	a_mac_to_div: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mac_step && sts.mac_last) |=> cmd.div_start)
		else $error("divide did not follow last MAC step");

endmodule

// ----- hw/rtl/cnf_dp.sv -----
// ----------------------------------------------------------------------------
// cnf_dp
// Datapath: config registers, line store, window, MAC, divider, result reg.
// ----------------------------------------------------------------------------
module cnf_dp #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [cnf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [cnf_pkg::CFG_W-1:0]     wr_data,
	input  logic [cnf_pkg::PIX_W-1:0]     pixel,
	input  cnf_pkg::cnf_cmd_t             cmd,
	output cnf_pkg::cnf_sts_t             sts,
	cnf_result_if.source                  res
);
	import cnf_pkg::*;

	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int GW  = (WB > GEOM_W) ? WB + 1 : GEOM_W + 1;

	logic [GEOM_W-1:0] fw_q, fh_q;
	logic [CFG_W-1:0]  kern_q [KSIZE];

	logic [CW-1:0]     col_q;
	logic [POS_W-1:0]  row_q;
	logic [PIX_W-1:0]  pix_q;
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0]  win_q [KTAPS];

	logic [GW-1:0]     w_eff, c_next;
	logic [HGT_W:0]    h_eff, r_next;
	logic              col_wrap, row_wrap, produce;
	logic              last_q;
	logic [POS_W-1:0]  orow_q, ocol_q;

	logic [TAP_IDX_W-1:0]    tap_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [NORM_W-1:0]       norm_q;
	logic signed [COEF_W-1:0] coef_sel;
	logic [COEF_W:0]         coef_mag;
	logic signed [PIX_W+COEF_W:0] prod;

	logic [DIV_W-1:0]     dq_q;
	logic [NORM_W-1:0]    rem_q;
	logic [NORM_W:0]      rem_sh;
	logic                 ge;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic                 neg_q, zk_q;
	logic [MAG_W-1:0]     mag;
	logic [FILT_W-1:0]    qlo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q      <= WIDTH_RST;
			fh_q      <= HEIGHT_RST;
			kern_q[0] <= KERNEL_TOP_RST;
			kern_q[1] <= KERNEL_MID_RST;
			kern_q[2] <= KERNEL_BOT_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_WIDTH:  fw_q      <= wr_data[GEOM_W-1:0];
				REG_FRAME_HEIGHT: fh_q      <= wr_data[GEOM_W-1:0];
				REG_KERNEL_TOP:   kern_q[0] <= wr_data;
				REG_KERNEL_MID:   kern_q[1] <= wr_data;
				REG_KERNEL_BOT:   kern_q[2] <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (fw_q == '0)
			w_eff = GW'(1);
		else if (GW'(fw_q) > GW'(MAX_WIDTH))
			w_eff = GW'(MAX_WIDTH);
		else
			w_eff = GW'(fw_q);
		if (fh_q == '0)
			h_eff = (HGT_W+1)'(1);
		else if ((HGT_W+1)'(fh_q) > (HGT_W+1)'(MAX_HEIGHT))
			h_eff = (HGT_W+1)'(MAX_HEIGHT);
		else
			h_eff = (HGT_W+1)'(fh_q);
		c_next   = GW'(col_q) + GW'(1);
		r_next   = (HGT_W+1)'(row_q) + (HGT_W+1)'(1);
		col_wrap = (c_next >= w_eff);
		row_wrap = (r_next >= h_eff);
		produce  = (row_q >= POS_W'(2)) && (col_q >= CW'(2));
	end

	// line store: [15:8] line above, [7:0] two lines above
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			rd_q  <= mem[col_q];
			pix_q <= pixel;
		end
		if (cmd.shift)
			mem[col_q] <= {pix_q, rd_q[2*PIX_W-1:PIX_W]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			last_q    <= 1'b0;
			for (int i = 0; i < KTAPS; i++) win_q[i] <= '0;
		end else if (cmd.shift) begin
			for (int r = 0; r < KSIZE; r++) begin
				win_q[r*KSIZE]   <= win_q[r*KSIZE+1];
				win_q[r*KSIZE+1] <= win_q[r*KSIZE+2];
			end
			win_q[2]  <= rd_q[PIX_W-1:0];
			win_q[5]  <= rd_q[2*PIX_W-1:PIX_W];
			win_q[8]  <= pix_q;
			last_q    <= col_wrap && row_wrap;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : r_next[POS_W-1:0];
			end else begin
				col_q <= c_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			orow_q <= row_q - POS_W'(1);
			ocol_q <= POS_W'(col_q) - POS_W'(1);
		end
	end

	// flipped kernel: window tap k pairs with coefficient 8-k
	always_comb begin
		logic [TAP_IDX_W-1:0] ci;
		logic [1:0]           kr;
		logic [1:0]           kc;
		logic [CFG_W-1:0]     krow;
		ci = TAP_IDX_W'(KTAPS - 1) - tap_q;
		if (ci >= TAP_IDX_W'(2 * KSIZE)) begin
			kr = 2'd2;
			kc = 2'(ci - TAP_IDX_W'(2 * KSIZE));
		end else if (ci >= TAP_IDX_W'(KSIZE)) begin
			kr = 2'd1;
			kc = 2'(ci - TAP_IDX_W'(KSIZE));
		end else begin
			kr = 2'd0;
			kc = 2'(ci);
		end
		krow     = kern_q[kr];
		coef_sel = $signed(krow[kc * COEF_W +: COEF_W]);
		coef_mag = coef_sel[COEF_W-1] ? (COEF_W+1)'(-$signed({coef_sel[COEF_W-1], coef_sel}))
			: (COEF_W+1)'(coef_sel);
		prod     = $signed({1'b0, win_q[tap_q]}) * coef_sel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (cmd.shift) begin
			tap_q <= '0;
		end else if (cmd.mac_step) begin
			tap_q <= tap_q + TAP_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			acc_q  <= '0;
			norm_q <= '0;
		end else if (cmd.mac_step) begin
			acc_q  <= acc_q + ACC_W'(prod);
			norm_q <= norm_q + NORM_W'(coef_mag);
		end
	end

	assign mag    = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
	assign rem_sh = {rem_q, dq_q[DIV_W-1]};
	assign ge     = (rem_sh >= {1'b0, norm_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.div_start) begin
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			dcnt_q <= dcnt_q + DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dq_q  <= {mag, {OUT_FRAC{1'b0}}};
			rem_q <= '0;
			neg_q <= acc_q[ACC_W-1];
			zk_q  <= (norm_q == '0);
		end else if (cmd.div_step) begin
			dq_q  <= {dq_q[DIV_W-2:0], ge};
			rem_q <= ge ? NORM_W'(rem_sh - {1'b0, norm_q}) : rem_sh[NORM_W-1:0];
		end
	end

	assign qlo = dq_q[FILT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (cmd.load_out) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res.filtered    <= zk_q ? '0 : (neg_q ? $signed(-qlo) : $signed(qlo));
			res.out_row     <= orow_q;
			res.out_col     <= ocol_q;
			res.frame_last  <= last_q;
			res.zero_kernel <= zk_q;
		end
	end

	always_comb begin
		sts.produce     = produce;
		sts.mac_last    = (tap_q == TAP_IDX_W'(KTAPS - 1));
		sts.div_last    = (dcnt_q == DIV_CNT_W'(DIV_W - 1));
		sts.zero_kernel = (norm_q == '0);
		sts.out_busy    = res.valid && !res.ready;
	end

	a_load_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> res.valid)
		else $error("result load did not raise valid");

	a_zk_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.zero_kernel) |-> (res.filtered == '0))
		else $error("zero kernel result not zero");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!res.valid || res.ready))
		else $error("pending result overwritten");

endmodule

// ----- hw/rtl/conv3x3_normalized_filter_unit.sv -----
// ----------------------------------------------------------------------------
// conv3x3_normalized_filter_unit
// 3x3 flipped-kernel convolution over a raster pixel stream, normalized by
// the sum of absolute kernel coefficients.
// ----------------------------------------------------------------------------
// One pixel is handled at a time. A pixel with no result (frame border)
// takes only a capture/line-store read and a window shift. An interior
// pixel goes on through the 9 taps of the shared multiply-accumulate, a
// divider load, 35 steps of the restoring divider and a result load, plus
// any wait on the result channel. With an all-zero kernel the divider is
// skipped. A finished result waits in the output register while the next
// pixel is taken. The line store is one MAX_WIDTH-deep memory of two-pixel
// words with a registered read; it needs no clearing.
module conv3x3_normalized_filter_unit #(
	parameter int MAX_WIDTH = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [cnf_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [cnf_pkg::CFG_W-1:0]     wr_data,
	cnf_pixel_if.sink                     pix,
	cnf_result_if.source                  res
);
	import cnf_pkg::*;

	cnf_cmd_t cmd;
	cnf_sts_t sts;

	cnf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pix.valid),
		.in_ready (pix.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	cnf_dp #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixel    (pix.pixel),
		.cmd      (cmd),
		.sts      (sts),
		.res      (res)
	);

endmodule
